>>> design/gssp_pkg.sv
// ----------------------------------------------------------------------------
// gssp_pkg
// Shared constants and types for the stance/swing phase mapper.
// ----------------------------------------------------------------------------
package gssp_pkg;

   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned DIV_STEPS = FRAC_BITS;
   localparam int unsigned CSR_IDX_W = 1;

   localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

   localparam logic [FRAC_BITS-1:0] DF_MAX   = FRAC_BITS'((ONE_Q * 9999) / 10000);
   localparam logic [FRAC_BITS-1:0] DF_MIN   = FRAC_BITS'(1);
   localparam logic [FRAC_BITS-1:0] DF_RESET = FRAC_BITS'((ONE_Q * 62) / 100);
   localparam logic [FRAC_BITS-1:0] ST_RESET = '0;
   localparam logic [FRAC_BITS-1:0] PROG_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_FACTOR  = 1'b0,
      CSR_STEP_TRIGGER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] duty_factor;
      logic [FRAC_BITS-1:0] step_trigger;
   } cfg_type;

   // one division in flight: stance flag, saturation flag, divisor, remainder and partial quotient
   typedef struct packed {
      logic                 in_stance;
      logic                 sat;
      logic [FRAC_BITS-1:0] den;
      logic [FRAC_BITS-1:0] rem;
      logic [FRAC_BITS-1:0] quo;
   } div_type;

endpackage

>>> design/gssp_if.sv
// ----------------------------------------------------------------------------
// gssp_req_if / gssp_rsp_if
// Valid/ready channels for phase requests and stance/swing results.
// ----------------------------------------------------------------------------
interface gssp_req_if;
   logic                           valid;
   logic                           ready;
   logic [gssp_pkg::FRAC_BITS-1:0] phase;

   modport source (output valid, output phase, input ready);
   modport sink   (input valid, input phase, output ready);
endinterface

interface gssp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           in_stance;
   logic [gssp_pkg::FRAC_BITS-1:0] stance_progress;
   logic [gssp_pkg::FRAC_BITS-1:0] swing_progress;

   modport source (output valid, output in_stance, output stance_progress,
                   output swing_progress, input ready);
   modport sink   (input valid, input in_stance, input stance_progress,
                   input swing_progress, output ready);
endinterface

>>> design/gssp_front.sv
// ----------------------------------------------------------------------------
// gssp_front
// Window classification of a phase request; sets up numerator and divisor.
// ----------------------------------------------------------------------------
module gssp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  gssp_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [gssp_pkg::FRAC_BITS-1:0] in_phase,
   output logic                           out_valid,
   input  logic                           out_ready,
   output gssp_pkg::div_type              out_data
);

   logic                           valid_ff, valid_in;
   gssp_pkg::div_type              data_ff, data_in, calc;
   logic [gssp_pkg::FRAC_BITS:0]   end_sum;
   logic [gssp_pkg::FRAC_BITS-1:0] swing_len;
   logic [gssp_pkg::FRAC_BITS-1:0] num;
   logic                           wraps;
   logic                           ge_st;
   logic                           stance;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      end_sum   = {1'b0, cfg.step_trigger} + {1'b0, cfg.duty_factor};
      wraps     = end_sum[gssp_pkg::FRAC_BITS] && (end_sum[gssp_pkg::FRAC_BITS-1:0] != '0);
      swing_len = '0 - cfg.duty_factor;
      ge_st     = in_phase >= cfg.step_trigger;
      if (wraps) begin
         stance = ge_st || (in_phase < end_sum[gssp_pkg::FRAC_BITS-1:0]);
      end else begin
         stance = ge_st && ({1'b0, in_phase} < end_sum);
      end
      // both wrap-around cases fall out of modulo arithmetic on the phase
      if (stance) begin
         num = in_phase - cfg.step_trigger;
      end else begin
         num = in_phase - end_sum[gssp_pkg::FRAC_BITS-1:0];
      end
      calc.in_stance = stance;
      calc.den       = stance ? cfg.duty_factor : swing_len;
      calc.rem       = num;
      calc.sat       = num >= calc.den;
      calc.quo       = '0;
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/gssp_cell.sv
// ----------------------------------------------------------------------------
// gssp_cell
// One restoring-division step: resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module gssp_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gssp_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output gssp_pkg::div_type out_data
);

   logic                         valid_ff, valid_in;
   gssp_pkg::div_type            data_ff, data_in, stepped;
   logic [gssp_pkg::FRAC_BITS:0] shifted;
   logic [gssp_pkg::FRAC_BITS:0] diff;
   logic                         take;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted     = {in_data.rem, 1'b0};
      diff        = shifted - {1'b0, in_data.den};
      take        = shifted >= {1'b0, in_data.den};
      stepped     = in_data;
      stepped.rem = take ? diff[gssp_pkg::FRAC_BITS-1:0] : shifted[gssp_pkg::FRAC_BITS-1:0];
      stepped.quo = {in_data.quo[gssp_pkg::FRAC_BITS-2:0], take};
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> design/gait_stance_swing_phase.sv
// Gait stance/swing phase mapper. One phase request is taken every cycle while
// the row is not stalled. A front register classifies the phase against
// the stance window, a row of 16 division cells resolves the normalised
// progress one quotient bit per cell, and one output register holds the
// result. A stalled result holds the row in place; gaps in the row close up
// while the output waits. Configuration writes are clamped on entry.
// ----------------------------------------------------------------------------
// gait_stance_swing_phase
// Top level: configuration registers, front stage, division row, output.
// ----------------------------------------------------------------------------
module gait_stance_swing_phase (
   input  logic                           clock,
   input  logic                           reset,
   gssp_req_if.sink                       req_ch,
   gssp_rsp_if.source                     rsp_ch,
   input  logic                           csr_write_enable,
   input  logic [gssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gssp_pkg::FRAC_BITS-1:0] csr_write_data
);

   gssp_pkg::cfg_type              cfg_ff, cfg_in;
   logic [gssp_pkg::FRAC_BITS-1:0] wr_hi;

   logic              link_valid [0:gssp_pkg::DIV_STEPS];
   logic              link_ready [0:gssp_pkg::DIV_STEPS];
   gssp_pkg::div_type link_data  [0:gssp_pkg::DIV_STEPS];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           in_stance_ff, in_stance_in;
   logic [gssp_pkg::FRAC_BITS-1:0] stance_prog_ff, stance_prog_in;
   logic [gssp_pkg::FRAC_BITS-1:0] swing_prog_ff, swing_prog_in;
   logic [gssp_pkg::FRAC_BITS-1:0] quotient;
   logic                           out_ready;

   // register writes, clamped
   always_comb begin
      cfg_in = cfg_ff;
      wr_hi  = (csr_write_data > gssp_pkg::DF_MAX) ? gssp_pkg::DF_MAX : csr_write_data;
      if (csr_write_enable) begin
         case (gssp_pkg::csr_index_type'(csr_index))
            gssp_pkg::CSR_DUTY_FACTOR: begin
               cfg_in.duty_factor = (wr_hi < gssp_pkg::DF_MIN) ? gssp_pkg::DF_MIN : wr_hi;
            end
            gssp_pkg::CSR_STEP_TRIGGER: begin
               cfg_in.step_trigger = wr_hi;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_factor  <= gssp_pkg::DF_RESET;
         cfg_ff.step_trigger <= gssp_pkg::ST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gssp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_phase  (req_ch.phase),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   for (genvar i = 0; i < gssp_pkg::DIV_STEPS; i++) begin : g_cell
      gssp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // output register
   assign out_ready                            = !rsp_valid_ff || rsp_ch.ready;
   assign link_ready[gssp_pkg::DIV_STEPS]      = out_ready;

   always_comb begin
      quotient = link_data[gssp_pkg::DIV_STEPS].sat ? gssp_pkg::PROG_MAX
                                                    : link_data[gssp_pkg::DIV_STEPS].quo;
      rsp_valid_in   = rsp_valid_ff;
      in_stance_in   = in_stance_ff;
      stance_prog_in = stance_prog_ff;
      swing_prog_in  = swing_prog_ff;
      if (out_ready) begin
         rsp_valid_in   = link_valid[gssp_pkg::DIV_STEPS];
         in_stance_in   = link_data[gssp_pkg::DIV_STEPS].in_stance;
         stance_prog_in = link_data[gssp_pkg::DIV_STEPS].in_stance ? quotient : '0;
         swing_prog_in  = link_data[gssp_pkg::DIV_STEPS].in_stance ? '0 : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      in_stance_ff   <= in_stance_in;
      stance_prog_ff <= stance_prog_in;
      swing_prog_ff  <= swing_prog_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.in_stance       = in_stance_ff;
   assign rsp_ch.stance_progress = stance_prog_ff;
   assign rsp_ch.swing_progress  = swing_prog_ff;

`ifndef SYNTHESIS
   a_stance_no_swing : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.in_stance) |-> (rsp_ch.swing_progress == '0))
      else $error("swing progress non-zero during stance");

   a_swing_no_stance : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.in_stance) |-> (rsp_ch.stance_progress == '0))
      else $error("stance progress non-zero during swing");

   a_duty_in_range : assert property (@(posedge clock) disable iff (reset)
      $past(csr_write_enable) |-> ((cfg_ff.duty_factor >= gssp_pkg::DF_MIN) &&
                                  (cfg_ff.duty_factor <= gssp_pkg::DF_MAX) &&
                                  (cfg_ff.step_trigger <= gssp_pkg::DF_MAX)))
      else $error("configuration register outside clamp range");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (link_valid[gssp_pkg::DIV_STEPS] && !out_ready) |=>
         link_valid[gssp_pkg::DIV_STEPS])
      else $error("result dropped from division row under back-pressure");
`endif

endmodule
